// ===== hdl/xor_framed_message_receiver_macros.svh =====
// Assertion macros used by the receiver's top-level RTL file.
`ifndef XOR_FRAMED_MESSAGE_RECEIVER_MACROS_SVH
`define XOR_FRAMED_MESSAGE_RECEIVER_MACROS_SVH

// The named condition must hold at every clock edge outside reset.
`define XFMR_ASSERT_ALWAYS(lbl, expr, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (expr)) else $error(msg);

// When the trigger holds, the consequence must hold at the next clock edge.
`define XFMR_ASSERT_NEXT(lbl, trig, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (trig) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/xfmr_pkg.sv =====
// Shared constants, codes and control types of the framed message receiver.
package xfmr_pkg;

  localparam int unsigned MAX_PAYLOAD = 32;
  localparam int unsigned IDX_W       = $clog2(MAX_PAYLOAD);
  localparam int unsigned LEN_W       = $clog2(MAX_PAYLOAD + 1);

  localparam logic [7:0] START_BYTE = 8'h3F;

  localparam logic [1:0] REG_TAG_CONFIG  = 2'd0;
  localparam logic [1:0] REG_TAG_MODE    = 2'd1;
  localparam logic [1:0] REG_TAG_COMMAND = 2'd2;

  typedef enum logic [1:0] {
    ST_GOOD     = 2'd0,
    ST_TYPE_ERR = 2'd1,
    ST_CSUM_ERR = 2'd2,
    ST_LEN_ERR  = 2'd3
  } status_e;

  typedef struct packed {
    logic    accept;
    logic    frame_start;
    logic    type_load;
    logic    len_load;
    logic    data_write;
    logic    play_start;
    logic    rd_en;
    logic    out_load_good;
    logic    out_load_err;
    status_e err_status;
  } ctrl_cmd_t;

  typedef struct packed {
    logic is_start;
    logic type_ok;
    logic len_bad;
    logic last_data;
    logic csum_ok;
    logic play_last;
    logic out_free;
  } dp_stat_t;

endpackage

// ===== hdl/xor_framed_message_receiver.sv =====
// Top level of the XOR-checksummed framed message receiver.
// The receiver takes one serial byte per item and hunts for the start byte 0x3F, then reads a
// type byte, a length byte of 1 to MAX_PAYLOAD, that many payload bytes and an XOR checksum
// byte. While framing, a byte is taken whenever the result register is free. A type, length or
// checksum error gives one result marked last. A good frame is played back from the payload RAM
// after its checksum byte: each payload byte is first read into the RAM's registered read data,
// then loaded into the result register once that is free. Input stays stalled until the last
// payload byte is loaded. The payload RAM needs no clearing after reset.
`include "xor_framed_message_receiver_macros.svh"

module xor_framed_message_receiver (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [7:0]  cfg_data_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,   // [7:0] frame_type, [13:8] byte_index,
                                      // [21:14] payload_byte, [23:22] zero
  output logic [1:0]  m_axis_tuser,   // [1:0] status
  output logic        m_axis_tlast    // last_of_run
);
  import xfmr_pkg::*;

  ctrl_cmd_t  cmd;
  dp_stat_t   stat;
  status_e    out_status;
  logic [7:0] out_type;
  logic [5:0] out_index;
  logic [7:0] out_payload;

  xfmr_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(s_axis_tvalid),
    .in_ready_o(s_axis_tready),
    .stat_i    (stat),
    .cmd_o     (cmd)
  );

  xfmr_datapath u_datapath (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_we_i          (cfg_we_i),
    .cfg_idx_i         (cfg_idx_i),
    .cfg_data_i        (cfg_data_i),
    .rx_byte_i         (s_axis_tdata),
    .cmd_i             (cmd),
    .stat_o            (stat),
    .out_ready_i       (m_axis_tready),
    .out_valid_o       (m_axis_tvalid),
    .out_status_o      (out_status),
    .out_frame_type_o  (out_type),
    .out_byte_index_o  (out_index),
    .out_payload_byte_o(out_payload),
    .out_last_o        (m_axis_tlast)
  );

  assign m_axis_tdata = {2'b00, out_payload, out_index, out_type};
  assign m_axis_tuser = out_status;

  `XFMR_ASSERT_ALWAYS(a_no_accept_over_stalled_result, !(s_axis_tvalid && s_axis_tready && m_axis_tvalid && !m_axis_tready), "byte accepted while a result is stalled")
  `XFMR_ASSERT_ALWAYS(a_error_result_shape, !m_axis_tvalid || (m_axis_tuser == ST_GOOD) || (m_axis_tlast && (out_payload == 8'd0) && (out_index == 6'd0)), "malformed error result")
  `XFMR_ASSERT_NEXT(a_playback_holds_input, m_axis_tvalid && m_axis_tready && (m_axis_tuser == ST_GOOD) && !m_axis_tlast, !s_axis_tready || (m_axis_tvalid && m_axis_tlast), "input taken during payload playback")

endmodule

// ===== hdl/xfmr_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module xfmr_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hdl/xfmr_datapath.sv =====
// Datapath: tag registers, frame fields, checksum, payload store and result register.
module xfmr_datapath (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [1:0]           cfg_idx_i,
  input  logic [7:0]           cfg_data_i,
  input  logic [7:0]           rx_byte_i,
  input  xfmr_pkg::ctrl_cmd_t  cmd_i,
  output xfmr_pkg::dp_stat_t   stat_o,
  input  logic                 out_ready_i,
  output logic                 out_valid_o,
  output xfmr_pkg::status_e    out_status_o,
  output logic [7:0]           out_frame_type_o,
  output logic [5:0]           out_byte_index_o,
  output logic [7:0]           out_payload_byte_o,
  output logic                 out_last_o
);
  import xfmr_pkg::*;

  logic [7:0]       tag_config_q, tag_mode_q, tag_command_q;
  logic [7:0]       xor_q, xor_d;
  logic [7:0]       held_type_q;
  logic [LEN_W-1:0] rem_q;
  logic [IDX_W-1:0] fill_q;
  logic [IDX_W-1:0] rd_idx_q;
  logic [7:0]       ram_rdata;

  logic             out_valid_q;
  status_e          out_status_q;
  logic [7:0]       out_type_q;
  logic [5:0]       out_index_q;
  logic [7:0]       out_payload_q;
  logic             out_last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tag_config_q  <= 8'd0;
      tag_mode_q    <= 8'd1;
      tag_command_q <= 8'd2;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_TAG_CONFIG:  tag_config_q  <= cfg_data_i;
        REG_TAG_MODE:    tag_mode_q    <= cfg_data_i;
        REG_TAG_COMMAND: tag_command_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign xor_d = (cmd_i.frame_start ? 8'd0 : xor_q) ^ rx_byte_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      xor_q       <= 8'd0;
      held_type_q <= 8'd0;
      rem_q       <= '0;
      fill_q      <= '0;
      rd_idx_q    <= '0;
    end else begin
      if (cmd_i.accept) begin
        xor_q <= xor_d;
      end
      if (cmd_i.type_load) begin
        held_type_q <= rx_byte_i;
      end
      if (cmd_i.frame_start || cmd_i.len_load) begin
        fill_q <= '0;
      end
      if (cmd_i.len_load) begin
        rem_q <= rx_byte_i[LEN_W-1:0];
      end
      if (cmd_i.data_write) begin
        if (rem_q > LEN_W'(1)) begin
          rem_q  <= rem_q - LEN_W'(1);
          fill_q <= fill_q + IDX_W'(1);
        end else begin
          rem_q <= '0;
        end
      end
      if (cmd_i.play_start) begin
        rd_idx_q <= '0;
      end else if (cmd_i.out_load_good) begin
        rd_idx_q <= rd_idx_q + IDX_W'(1);
      end
    end
  end

  xfmr_ram #(
    .WIDTH(8),
    .DEPTH(MAX_PAYLOAD)
  ) u_store (
    .clk_i  (clk_i),
    .we_i   (cmd_i.data_write),
    .waddr_i(fill_q),
    .wdata_i(rx_byte_i),
    .re_i   (cmd_i.rd_en),
    .raddr_i(rd_idx_q),
    .rdata_o(ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load_good || cmd_i.out_load_err) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load_good) begin
      out_status_q  <= ST_GOOD;
      out_type_q    <= held_type_q;
      out_index_q   <= 6'(rd_idx_q);
      out_payload_q <= ram_rdata;
      out_last_q    <= (rd_idx_q == fill_q);
    end else if (cmd_i.out_load_err) begin
      out_status_q  <= cmd_i.err_status;
      out_type_q    <= cmd_i.type_load ? rx_byte_i : held_type_q;
      out_index_q   <= 6'd0;
      out_payload_q <= 8'd0;
      out_last_q    <= 1'b1;
    end
  end

  assign stat_o.is_start  = (rx_byte_i == START_BYTE);
  assign stat_o.type_ok   = (rx_byte_i == tag_config_q) || (rx_byte_i == tag_mode_q) ||
                            (rx_byte_i == tag_command_q);
  assign stat_o.len_bad   = (rx_byte_i == 8'd0) || (rx_byte_i > 8'(MAX_PAYLOAD));
  assign stat_o.last_data = (rem_q <= LEN_W'(1));
  assign stat_o.csum_ok   = (rx_byte_i == xor_q);
  assign stat_o.play_last = (rd_idx_q == fill_q);
  assign stat_o.out_free  = !out_valid_q || out_ready_i;

  assign out_valid_o        = out_valid_q;
  assign out_status_o       = out_status_q;
  assign out_frame_type_o   = out_type_q;
  assign out_byte_index_o   = out_index_q;
  assign out_payload_byte_o = out_payload_q;
  assign out_last_o         = out_last_q;

endmodule

// ===== hdl/xfmr_ctrl.sv =====
// Controller: frame phase state machine and payload playback sequencing.
module xfmr_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  xfmr_pkg::dp_stat_t  stat_i,
  output xfmr_pkg::ctrl_cmd_t cmd_o
);
  import xfmr_pkg::*;

  typedef enum logic [2:0] {
    S_HUNT,
    S_TYPE,
    S_LEN,
    S_DATA,
    S_CSUM,
    S_PLAY_RD,
    S_PLAY_WR
  } state_e;

  state_e state_q, state_d;
  logic   ready;
  logic   acc;

  always_comb begin
    ready = 1'b0;
    unique case (state_q)
      S_HUNT, S_TYPE, S_LEN, S_DATA, S_CSUM: ready = stat_i.out_free;
      S_PLAY_RD, S_PLAY_WR:                  ready = 1'b0;
      default:                               ready = 1'b0;
    endcase
  end

  assign acc = in_valid_i && ready;

  always_comb begin
    cmd_o            = '0;
    cmd_o.err_status = ST_GOOD;
    cmd_o.accept     = acc;
    state_d          = state_q;
    unique case (state_q)
      S_HUNT: begin
        if (acc && stat_i.is_start) begin
          cmd_o.frame_start = 1'b1;
          state_d           = S_TYPE;
        end
      end
      S_TYPE: begin
        if (acc) begin
          cmd_o.type_load = 1'b1;
          if (stat_i.type_ok) begin
            state_d = S_LEN;
          end else begin
            cmd_o.out_load_err = 1'b1;
            cmd_o.err_status   = ST_TYPE_ERR;
            state_d            = S_HUNT;
          end
        end
      end
      S_LEN: begin
        if (acc) begin
          if (stat_i.len_bad) begin
            cmd_o.out_load_err = 1'b1;
            cmd_o.err_status   = ST_LEN_ERR;
            state_d            = S_HUNT;
          end else begin
            cmd_o.len_load = 1'b1;
            state_d        = S_DATA;
          end
        end
      end
      S_DATA: begin
        if (acc) begin
          cmd_o.data_write = 1'b1;
          if (stat_i.last_data) begin
            state_d = S_CSUM;
          end
        end
      end
      S_CSUM: begin
        if (acc) begin
          if (stat_i.csum_ok) begin
            cmd_o.play_start = 1'b1;
            state_d          = S_PLAY_RD;
          end else begin
            cmd_o.out_load_err = 1'b1;
            cmd_o.err_status   = ST_CSUM_ERR;
            state_d            = S_HUNT;
          end
        end
      end
      S_PLAY_RD: begin
        cmd_o.rd_en = 1'b1;
        state_d     = S_PLAY_WR;
      end
      S_PLAY_WR: begin
        if (stat_i.out_free) begin
          cmd_o.out_load_good = 1'b1;
          state_d             = stat_i.play_last ? S_HUNT : S_PLAY_RD;
        end
      end
      default: state_d = S_HUNT;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_HUNT;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_ready_o = ready;

endmodule

// ===== tb/xfmr_frame_checker.sv =====
// Checker that predicts the receiver's results from the bytes it accepts and compares them.
`timescale 1ns / 1ps

module xfmr_frame_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [7:0]  cfg_data_i,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [23:0] m_axis_tdata,   // [7:0] frame_type, [13:8] byte_index,
                                      // [21:14] payload_byte, [23:22] zero
  input  logic [1:0]  m_axis_tuser,   // [1:0] status
  input  logic        m_axis_tlast,
  output int          fail_count_o,
  output int          pending_o
);
  import xfmr_pkg::*;

  typedef enum logic [2:0] {
    PH_HUNT,
    PH_TYPE_BYTE,
    PH_LEN_BYTE,
    PH_DATA_BYTE,
    PH_CSUM_BYTE
  } rx_phase_e;

  typedef struct packed {
    status_e    status;
    logic [7:0] frame_type;
    logic [5:0] byte_index;
    logic [7:0] payload_byte;
    logic       last;
  } frame_result_t;

  logic [7:0]    tag_cfg_q, tag_mode_q, tag_cmd_q;
  rx_phase_e     phase_q;
  logic [7:0]    xor_sum_q;
  logic [7:0]    held_type_q;
  logic [7:0]    remaining_q;
  logic [5:0]    fill_pos_q;
  logic [7:0]    payload_mem [MAX_PAYLOAD];
  frame_result_t expected_results[$];
  int            mismatches;

  initial begin
    fail_count_o = 0;
    pending_o    = 0;
    mismatches   = 0;
  end

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("%0t ns: mismatch in %s: got 0x%0h, expected 0x%0h", $realtime, what, got, want);
    mismatches++;
  endtask

  task automatic push_result(input status_e st, input logic [7:0] ftype,
                             input logic [5:0] idx, input logic [7:0] value, input logic last);
    frame_result_t r;
    r.status       = st;
    r.frame_type   = ftype;
    r.byte_index   = idx;
    r.payload_byte = value;
    r.last         = last;
    expected_results.push_back(r);
  endtask

  task automatic advance_deframer(input logic [7:0] rx);
    int i;
    case (phase_q)
      PH_HUNT: begin
        if (rx == START_BYTE) begin
          xor_sum_q  = 8'h00;
          fill_pos_q = '0;
          phase_q    = PH_TYPE_BYTE;
        end
      end
      PH_TYPE_BYTE: begin
        held_type_q = rx;
        if (rx != tag_cfg_q && rx != tag_mode_q && rx != tag_cmd_q) begin
          push_result(ST_TYPE_ERR, rx, '0, 8'h00, 1'b1);
          phase_q = PH_HUNT;
        end else begin
          phase_q = PH_LEN_BYTE;
        end
      end
      PH_LEN_BYTE: begin
        if (rx == 8'd0 || rx > MAX_PAYLOAD) begin
          push_result(ST_LEN_ERR, held_type_q, '0, 8'h00, 1'b1);
          remaining_q = 8'd0;
          phase_q     = PH_HUNT;
        end else begin
          remaining_q = rx;
          fill_pos_q  = '0;
          phase_q     = PH_DATA_BYTE;
        end
      end
      PH_DATA_BYTE: begin
        if (fill_pos_q < MAX_PAYLOAD) payload_mem[fill_pos_q] = rx;
        if (remaining_q <= 8'd1) begin
          remaining_q = 8'd0;
          phase_q     = PH_CSUM_BYTE;
        end else begin
          remaining_q = remaining_q - 8'd1;
          fill_pos_q  = fill_pos_q + 6'd1;
        end
      end
      PH_CSUM_BYTE: begin
        if (rx != xor_sum_q) begin
          push_result(ST_CSUM_ERR, held_type_q, '0, 8'h00, 1'b1);
        end else begin
          for (i = 0; i <= int'(fill_pos_q) && i < MAX_PAYLOAD; i++) begin
            push_result(ST_GOOD, held_type_q, 6'(i), payload_mem[i], i == int'(fill_pos_q));
          end
        end
        phase_q = PH_HUNT;
      end
      default: phase_q = PH_HUNT;
    endcase
    xor_sum_q = xor_sum_q ^ rx;
  endtask

  task automatic check_result();
    frame_result_t want;
    if (expected_results.size() == 0) begin
      report_mismatch("unexpected result, frame_type", m_axis_tdata[7:0], 0);
    end else begin
      want = expected_results.pop_front();
      if (m_axis_tuser != want.status) report_mismatch("status", m_axis_tuser, want.status);
      if (m_axis_tdata[7:0] != want.frame_type)
        report_mismatch("frame_type", m_axis_tdata[7:0], want.frame_type);
      if (m_axis_tdata[13:8] != want.byte_index)
        report_mismatch("byte_index", m_axis_tdata[13:8], want.byte_index);
      if (m_axis_tdata[21:14] != want.payload_byte)
        report_mismatch("payload_byte", m_axis_tdata[21:14], want.payload_byte);
      if (m_axis_tlast != want.last) report_mismatch("last_of_run", m_axis_tlast, want.last);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tag_cfg_q   = 8'd0;
      tag_mode_q  = 8'd1;
      tag_cmd_q   = 8'd2;
      phase_q     = PH_HUNT;
      xor_sum_q   = 8'h00;
      held_type_q = 8'h00;
      remaining_q = 8'd0;
      fill_pos_q  = '0;
      expected_results.delete();
      pending_o <= 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_TAG_CONFIG:  tag_cfg_q  = cfg_data_i;
          REG_TAG_MODE:    tag_mode_q = cfg_data_i;
          REG_TAG_COMMAND: tag_cmd_q  = cfg_data_i;
          default: ;
        endcase
      end
      if (s_axis_tvalid && s_axis_tready) advance_deframer(s_axis_tdata);
      if (m_axis_tvalid && m_axis_tready) check_result();
      pending_o    <= expected_results.size();
      fail_count_o <= mismatches;
    end
  end

endmodule

// ===== tb/xor_framed_message_receiver_tb.sv =====
// Top of the receiver testbench: stimulus, stalls, configuration phases and the verdict.
`timescale 1ns / 1ps

module xor_framed_message_receiver_tb;
  import xfmr_pkg::*;

  localparam logic [1:0] REG_UNUSED = 2'd3;
  localparam int DRAIN_CYCLES = 8;
  localparam int RDY_ALWAYS = 0;
  localparam int RDY_RANDOM = 1;
  localparam int RDY_BURSTY = 2;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [1:0]  cfg_idx_i = '0;
  logic [7:0]  cfg_data_i = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = '0;    // [7:0] rx_byte
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [23:0] m_axis_tdata;         // [7:0] frame_type, [13:8] byte_index,
                                     // [21:14] payload_byte, [23:22] zero
  logic [1:0]  m_axis_tuser;         // [1:0] status
  logic        m_axis_tlast;
  int          fail_count;
  int          pending;

  logic [7:0]  tags [3];
  int          burst_left = 0;
  int          items_sent = 0;
  int          rdy_mode = RDY_ALWAYS;
  int          rdy_cycle = 0;
  int          stall_left = 0;

  always #2 clk_i = ~clk_i;

  xor_framed_message_receiver uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  xfmr_frame_checker checker_i (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .fail_count_o  (fail_count),
    .pending_o     (pending)
  );

  // The result side switches between always ready, coin-flip ready and stall bursts.
  always @(posedge clk_i) begin
    rdy_cycle++;
    if (rdy_cycle % 64 == 0) rdy_mode = $urandom_range(RDY_ALWAYS, RDY_BURSTY);
    case (rdy_mode)
      RDY_ALWAYS: m_axis_tready <= 1'b1;
      RDY_RANDOM: m_axis_tready <= 1'($urandom_range(0, 1));
      default: begin
        if (stall_left > 0) begin
          stall_left--;
          m_axis_tready <= 1'b0;
        end else begin
          stall_left = $urandom_range(0, 7);
          m_axis_tready <= 1'b1;
        end
      end
    endcase
  end

  task automatic send_byte(input logic [7:0] b);
    if (burst_left == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
      burst_left = ($urandom_range(0, 7) == 0) ? 60 : $urandom_range(1, 16);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    do @(posedge clk_i); while (!s_axis_tready);
    burst_left--;
    items_sent++;
  endtask

  task automatic send_frame(input logic [7:0] ftype, input int len, input logic bad_sum);
    logic [7:0] sum;
    logic [7:0] b;
    int i;
    sum = START_BYTE ^ ftype ^ 8'(len);
    send_byte(START_BYTE);
    send_byte(ftype);
    send_byte(8'(len));
    for (i = 0; i < len; i++) begin
      b = $urandom_range(0, 255);
      sum ^= b;
      send_byte(b);
    end
    if (bad_sum) sum ^= 8'($urandom_range(1, 255));
    send_byte(sum);
  endtask

  task automatic send_random_frame();
    int pick;
    int len;
    logic [7:0] b;
    pick = $urandom_range(0, 99);
    if (pick < 70) begin
      case ($urandom_range(0, 9))
        0:       len = MAX_PAYLOAD;
        1:       len = $urandom_range(9, MAX_PAYLOAD - 1);
        default: len = $urandom_range(1, 8);
      endcase
      send_frame(tags[$urandom_range(0, 2)], len, pick >= 60);
    end else if (pick < 77) begin
      b = $urandom_range(0, 255);
      while (b == tags[0] || b == tags[1] || b == tags[2]) b = $urandom_range(0, 255);
      send_byte(START_BYTE);
      send_byte(b);
    end else if (pick < 85) begin
      send_byte(START_BYTE);
      send_byte(tags[$urandom_range(0, 2)]);
      send_byte(($urandom_range(0, 2) == 0) ? 8'd0 : 8'($urandom_range(MAX_PAYLOAD + 1, 255)));
    end else begin
      repeat ($urandom_range(1, 3)) send_byte(8'($urandom_range(0, 255)));
    end
  endtask

  task automatic run_random(input int count);
    int target;
    target = items_sent + count;
    while (items_sent < target) send_random_frame();
  endtask

  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    burst_left = 0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [7:0] value);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic set_tags(input logic [7:0] t_cfg, input logic [7:0] t_mode,
                          input logic [7:0] t_cmd);
    write_reg(REG_TAG_CONFIG, t_cfg);
    write_reg(REG_TAG_MODE, t_mode);
    write_reg(REG_TAG_COMMAND, t_cmd);
    tags[0] = t_cfg;
    tags[1] = t_mode;
    tags[2] = t_cmd;
  endtask

  initial begin
    #2_000_000;
    $display("Regression FAIL");
    $finish;
  end

  initial begin
    tags[0] = 8'd0;
    tags[1] = 8'd1;
    tags[2] = 8'd2;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Bytes seen while hunting are dropped.
    send_byte(8'h00);
    send_byte(8'hFF);
    // Good one-byte frame.
    send_byte(START_BYTE);
    send_byte(tags[0]);
    send_byte(8'd1);
    send_byte(8'hFF);
    send_byte(START_BYTE ^ tags[0] ^ 8'd1 ^ 8'hFF);
    // Unknown type.
    send_byte(START_BYTE);
    send_byte(8'h80);
    // Zero length, oversized length and the largest length byte.
    send_byte(START_BYTE);
    send_byte(tags[1]);
    send_byte(8'd0);
    send_byte(START_BYTE);
    send_byte(tags[2]);
    send_byte(8'(MAX_PAYLOAD + 1));
    send_byte(START_BYTE);
    send_byte(tags[1]);
    send_byte(8'hFF);
    // A start byte as payload, followed by a wrong checksum.
    send_byte(START_BYTE);
    send_byte(tags[2]);
    send_byte(8'd1);
    send_byte(START_BYTE);
    send_byte(tags[2] ^ 8'd1 ^ 8'h01);
    run_random(30);

    wait_idle();
    set_tags(8'hFF, 8'h00, START_BYTE);
    write_reg(REG_UNUSED, 8'h5A);
    run_random(35);

    wait_idle();
    set_tags(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
             8'($urandom_range(0, 255)));
    run_random(35);

    wait_idle();
    set_tags(8'h80, 8'h7F, 8'h80);
    run_random(30);

    wait_idle();
    repeat (20) @(posedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
